FILE: hw/rtl/tbpf_pkg.sv
// ----------------------------------------------------------------------------
// tbpf_pkg
// Types and constants shared by the tiled background pixel fetch design.
// ----------------------------------------------------------------------------
package tbpf_pkg;

   // transaction kinds on the request channel (req_tuser)
   typedef enum logic [1:0] {
      OP_WRITE_VIDEO   = 2'd0,
      OP_WRITE_PALETTE = 2'd1,
      OP_RENDER        = 2'd2,
      OP_RESERVED      = 2'd3
   } op_type;

   // csr register indexes
   localparam logic [1:0] CSR_LAYER_CONTROL = 2'd0;
   localparam logic [1:0] CSR_DISPLAY_MODE  = 2'd1;
   localparam logic [1:0] CSR_LAYER_INDEX   = 2'd2;
   localparam logic [1:0] CSR_FRAME_SELECT  = 2'd3;

   // display modes
   localparam logic [2:0] MODE_TEXT     = 3'd0;
   localparam logic [2:0] MODE_MIXED    = 3'd1;
   localparam logic [2:0] MODE_ROTATION = 3'd2;
   localparam logic [2:0] MODE_BMP_WIDE = 3'd3;
   localparam logic [2:0] MODE_BMP_IDX  = 3'd4;
   localparam logic [2:0] MODE_BMP_NARR = 3'd5;

   localparam logic [1:0] ROT_LAYER = 2'd2;

   // bitmap geometry
   localparam logic [9:0]  BMP_WIDE_W   = 10'd240;
   localparam logic [9:0]  BMP_WIDE_H   = 10'd160;
   localparam logic [9:0]  BMP_NARR_W   = 10'd160;
   localparam logic [9:0]  BMP_NARR_H   = 10'd128;
   localparam logic [15:0] BMP_WIDE_MUL = 16'd240;
   localparam logic [15:0] BMP_NARR_MUL = 16'd160;
   localparam logic [16:0] PAGE_BYTES   = 17'h0A000;
   localparam logic [15:0] PAGE_HALVES  = 16'h5000;
   localparam logic [10:0] ROT_MIN_SIZE = 11'd128;

   localparam int PAL_ENTRIES = 256;

   // stream packing
   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic [2:0] {
      KIND_TEXT4   = 3'd0,
      KIND_TEXT8   = 3'd1,
      KIND_ROT     = 3'd2,
      KIND_DIRECT  = 3'd3,
      KIND_INDEXED = 3'd4,
      KIND_NONE    = 3'd5
   } kind_type;

   // map read stage
   typedef struct packed {
      kind_type    kind;
      logic        outside;
      logic [15:0] addr;
      logic        bsel;
      logic [2:0]  xl;
      logic [2:0]  yl;
   } map_stage_type;

   // tile read stage
   typedef struct packed {
      kind_type    kind;
      logic        outside;
      logic [15:0] addr;
      logic        bsel;
      logic        nsel;
      logic [3:0]  bank;
      logic [15:0] word;
   } tile_stage_type;

   // palette read stage
   typedef struct packed {
      kind_type    kind;
      logic        outside;
      logic [15:0] word;
   } pal_stage_type;

endpackage

FILE: hw/rtl/tiled_background_pixel_fetch_top.sv
// ----------------------------------------------------------------------------
// tiled_background_pixel_fetch_top
// Background pixel fetch: text, rotation and bitmap layers out of video memory.
// ----------------------------------------------------------------------------
// usage
//   req channel: tuser carries the operation. write transactions load video
//   memory or the palette and give no response; render transactions give one
//   rsp transaction with rgb in tdata and the outside flag in tuser.
//   csr port: layer control, display mode, layer index and frame select, to
//   be written only while no render is in flight; not enforced by the block.
// pipeline and throughput
//   a render passes six register stages: map address, map read, tile address,
//   tile read, palette read, colour and output register. the two video memory
//   reads and the palette read sit in separate stages, so one render or one
//   write is taken every cycle, but for the stall and the wait below. a write
//   that follows a render waits until the renders ahead of it have done their
//   memory reads (the wait grows while rsp stalls), since writes land in memory
//   at the request.
// reset
//   clears the pipeline valids, the response valid and the csr registers. memory
//   contents are undefined until written.
// stall
//   when rsp_tready is low the response holds and stages fill behind it;
//   render requests are taken as long as the first stage can move.
// ----------------------------------------------------------------------------
module tiled_background_pixel_fetch_top
   import tbpf_pkg::*;
#(
   parameter int VIDEO_HALFWORDS = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // write_address[15:0], write_value[31:16], pixel_x[41:32], pixel_y[51:42]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // red[7:0], green[15:8], blue[23:16]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // outside_map[0]
   output logic                   rsp_tuser,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_wdata
);

   localparam int AW = $clog2(VIDEO_HALFWORDS);
   localparam logic [16:0] VMEM_DEPTH = 17'(VIDEO_HALFWORDS);

   // csr
   logic [15:0] lc_ff;
   logic [2:0]  mode_ff;
   logic [1:0]  layer_ff;
   logic        fs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff    <= '0;
         mode_ff  <= '0;
         layer_ff <= '0;
         fs_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LAYER_CONTROL: lc_ff    <= csr_wdata;
            CSR_DISPLAY_MODE:  mode_ff  <= csr_wdata[2:0];
            CSR_LAYER_INDEX:   layer_ff <= csr_wdata[1:0];
            CSR_FRAME_SELECT:  fs_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // request fields
   op_type      op;
   logic [15:0] waddr;
   logic [15:0] wval;
   logic [9:0]  px;
   logic [9:0]  py;

   assign op    = op_type'(req_tuser);
   assign waddr = req_tdata[15:0];
   assign wval  = req_tdata[31:16];
   assign px    = req_tdata[41:32];
   assign py    = req_tdata[51:42];

   // pipeline registers
   logic           s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   map_stage_type  s1_ff, s1_in, s2_ff;
   tile_stage_type s3_ff, s3_in, s4_ff;
   pal_stage_type  s5_ff;
   logic [15:0]    rd_a_ff, rd_b_ff, rd_p_ff;
   logic           rsp_valid_ff;
   logic [23:0]    rsp_data_ff, rsp_data_in;
   logic           rsp_user_ff;

   logic ld1, ld2, ld3, ld4, ld5, ld_out;
   logic busy;
   logic acc, acc_render;

   assign ld_out = !rsp_valid_ff || rsp_tready;
   assign ld5    = !s5_v_ff || ld_out;
   assign ld4    = !s4_v_ff || ld5;
   assign ld3    = !s3_v_ff || ld4;
   assign ld2    = !s2_v_ff || ld3;
   assign ld1    = !s1_v_ff || ld2;
   assign busy   = s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff;

   always_comb begin
      case (op)
         OP_RENDER:        req_tready = ld1;
         OP_WRITE_VIDEO,
         OP_WRITE_PALETTE: req_tready = !busy;
         default:          req_tready = 1'b1;
      endcase
   end

   assign acc        = req_tvalid && req_tready;
   assign acc_render = acc && (op == OP_RENDER);

   // memories
   logic [15:0] vmem_ff [VIDEO_HALFWORDS];
   logic [15:0] pal_ff  [PAL_ENTRIES];

   always_ff @(posedge clock) begin
      if (acc && (op == OP_WRITE_VIDEO) && ({1'b0, waddr} < VMEM_DEPTH)) begin
         vmem_ff[waddr[AW-1:0]] <= wval;
      end
      if (acc && (op == OP_WRITE_PALETTE)) begin
         pal_ff[waddr[7:0]] <= wval;
      end
   end

   // stage 0: map or frame buffer address
   logic [1:0]  size;
   logic [1:0]  blk;
   logic [10:0] rot_n;
   logic [16:0] rot_byte;
   logic [15:0] wide_half;
   logic [16:0] idx_byte;
   logic [15:0] narr_half;
   logic        text_out, rot_out, wide_out, narr_out;
   logic        use_rot;

   always_comb begin
      size      = lc_ff[15:14];
      text_out  = px[9] || (px[8] && !size[0]) || py[9] || (py[8] && !size[1]);
      blk       = {1'b0, px[8]} + (py[8] ? (size[0] ? 2'd2 : 2'd1) : 2'd0);
      rot_n     = ROT_MIN_SIZE << size;
      rot_out   = ({1'b0, px} >= rot_n) || ({1'b0, py} >= rot_n);
      rot_byte  = 17'({lc_ff[12:8], 11'b0}) + (17'(py[9:3]) << (3'd4 + 3'(size)))
                  + 17'(px[9:3]);
      wide_half = 16'(py[7:0]) * BMP_WIDE_MUL + 16'(px[7:0]);
      idx_byte  = (fs_ff ? PAGE_BYTES : 17'd0) + 17'(wide_half);
      narr_half = (fs_ff ? PAGE_HALVES : 16'd0) + 16'(py[6:0]) * BMP_NARR_MUL
                  + 16'(px[7:0]);
      wide_out  = (px >= BMP_WIDE_W) || (py >= BMP_WIDE_H);
      narr_out  = (px >= BMP_NARR_W) || (py >= BMP_NARR_H);
      use_rot   = (mode_ff == MODE_ROTATION) ||
                  ((mode_ff == MODE_MIXED) && (layer_ff == ROT_LAYER));

      s1_in.xl      = px[2:0];
      s1_in.yl      = py[2:0];
      s1_in.kind    = lc_ff[7] ? KIND_TEXT8 : KIND_TEXT4;
      s1_in.outside = text_out;
      s1_in.addr    = {6'(lc_ff[12:8]) + 6'(blk), py[7:3], px[7:3]};
      s1_in.bsel    = 1'b0;
      case (mode_ff)
         MODE_TEXT, MODE_MIXED, MODE_ROTATION: begin
            if (use_rot) begin
               s1_in.kind    = KIND_ROT;
               s1_in.outside = rot_out;
               s1_in.addr    = rot_byte[16:1];
               s1_in.bsel    = rot_byte[0];
            end
         end
         MODE_BMP_WIDE: begin
            s1_in.kind    = KIND_DIRECT;
            s1_in.outside = wide_out;
            s1_in.addr    = wide_half;
         end
         MODE_BMP_IDX: begin
            s1_in.kind    = KIND_INDEXED;
            s1_in.outside = wide_out;
            s1_in.addr    = idx_byte[16:1];
            s1_in.bsel    = idx_byte[0];
         end
         MODE_BMP_NARR: begin
            s1_in.kind    = KIND_DIRECT;
            s1_in.outside = narr_out;
            s1_in.addr    = narr_half;
         end
         default: begin
            s1_in.kind    = KIND_NONE;
            s1_in.outside = 1'b1;
         end
      endcase
   end

   // stage 2: tile address from the map entry
   logic [2:0]  tx, ty;
   logic [7:0]  map_byte;
   logic [15:0] cbase_half;

   always_comb begin
      tx         = rd_a_ff[10] ? ~s2_ff.xl : s2_ff.xl;
      ty         = rd_a_ff[11] ? ~s2_ff.yl : s2_ff.yl;
      map_byte   = s2_ff.bsel ? rd_a_ff[15:8] : rd_a_ff[7:0];
      cbase_half = {lc_ff[3:2], 14'b0} >> 1;

      s3_in.kind    = s2_ff.kind;
      s3_in.outside = s2_ff.outside;
      s3_in.addr    = '0;
      s3_in.bsel    = 1'b0;
      s3_in.nsel    = 1'b0;
      s3_in.bank    = rd_a_ff[15:12];
      s3_in.word    = rd_a_ff;
      case (s2_ff.kind)
         KIND_TEXT8: begin
            s3_in.addr = cbase_half + 16'({rd_a_ff[9:0], ty, tx[2:1]});
            s3_in.bsel = tx[0];
         end
         KIND_TEXT4: begin
            s3_in.addr = cbase_half + 16'({rd_a_ff[9:0], ty, tx[2]});
            s3_in.bsel = tx[1];
            s3_in.nsel = tx[0];
         end
         KIND_ROT: begin
            s3_in.addr = cbase_half + 16'({map_byte, s2_ff.yl, s2_ff.xl[2:1]});
            s3_in.bsel = s2_ff.xl[0];
         end
         KIND_INDEXED: s3_in.word = {8'b0, map_byte};
         default: ;
      endcase
   end

   // stage 3: wrap the tile address into video memory
   logic [16:0] tile_wrap;

   assign tile_wrap = ({1'b0, s3_ff.addr} >= VMEM_DEPTH) ?
                      ({1'b0, s3_ff.addr} - VMEM_DEPTH) : {1'b0, s3_ff.addr};

   // stage 4: palette index
   logic [7:0] tile_byte;
   logic [7:0] pal_idx;

   always_comb begin
      tile_byte = s4_ff.bsel ? rd_b_ff[15:8] : rd_b_ff[7:0];
      case (s4_ff.kind)
         KIND_TEXT4: pal_idx = {s4_ff.bank, s4_ff.nsel ? tile_byte[7:4] : tile_byte[3:0]};
         KIND_TEXT8, KIND_ROT: pal_idx = tile_byte;
         default: pal_idx = s4_ff.word[7:0];
      endcase
   end

   // stage 5: colour
   logic [15:0] col;

   always_comb begin
      col         = (s5_ff.kind == KIND_DIRECT) ? s5_ff.word : rd_p_ff;
      rsp_data_in = s5_ff.outside ? 24'd0 :
                    {col[14:10], 3'b0, col[9:5], 3'b0, col[4:0], 3'b0};
   end

   // valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         s5_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld1)    s1_v_ff      <= acc_render;
         if (ld2)    s2_v_ff      <= s1_v_ff;
         if (ld3)    s3_v_ff      <= s2_v_ff;
         if (ld4)    s4_v_ff      <= s3_v_ff;
         if (ld5)    s5_v_ff      <= s4_v_ff;
         if (ld_out) rsp_valid_ff <= s5_v_ff;
      end
   end

   // payload and memory reads
   always_ff @(posedge clock) begin
      if (ld1) s1_ff <= s1_in;
      if (ld2) begin
         s2_ff   <= s1_ff;
         rd_a_ff <= vmem_ff[s1_ff.addr[AW-1:0]];
      end
      if (ld3) s3_ff <= s3_in;
      if (ld4) begin
         s4_ff   <= s3_ff;
         rd_b_ff <= vmem_ff[tile_wrap[AW-1:0]];
      end
      if (ld5) begin
         s5_ff   <= '{kind: s4_ff.kind, outside: s4_ff.outside, word: s4_ff.word};
         rd_p_ff <= pal_ff[pal_idx];
      end
      if (ld_out) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= s5_ff.outside;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   a_render_enters: assert property (@(posedge clock) disable iff (reset)
      acc_render |=> s1_v_ff)
      else $error("accepted render did not enter the pipeline");

   a_last_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s5_v_ff && rsp_valid_ff && !rsp_tready) |=> s5_v_ff)
      else $error("pending result dropped during stall");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s5_v_ff))
      else $error("response without a pipeline result");

   a_outside_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |-> (rsp_data_ff == 24'd0))
      else $error("outside pixel carries colour");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tiled background pixel fetch block. A scoreboard
// keeps its own copy of video memory, the palette and the csr registers, works
// out every rendered pixel as each request is taken, and checks the responses
// in order. Before a render, every video word and palette entry that the pixel
// needs is loaded with random content. Directed pixels come first, then random
// traffic over twelve csr settings, eight with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tbpf_pkg::*;

   localparam int VIDEO_WORDS  = 65536;
   localparam int RANDOM_ITEMS = 1400;
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE       = 10;
   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       outside_map;
   } pixel_type;

   class bg_pixel_scoreboard_type;
      logic [15:0] vram [0:VIDEO_WORDS-1];
      bit          vram_set [0:VIDEO_WORDS-1];
      logic [15:0] palette [0:PAL_ENTRIES-1];
      bit          palette_set [0:PAL_ENTRIES-1];
      logic [15:0] layer_control = '0;
      logic [2:0]  display_mode  = MODE_TEXT;
      logic [1:0]  layer_index   = '0;
      logic        frame_select  = 1'b0;
      bit          missing;
      bit          missing_pal;
      int          missing_addr;
      int          touched[$];
      pixel_type   pixels_due[$];
      int          errors;

      function void set_reg(logic [1:0] index, logic [15:0] value);
         case (index)
            CSR_LAYER_CONTROL: layer_control = value;
            CSR_DISPLAY_MODE:  display_mode = value[2:0];
            CSR_LAYER_INDEX:   layer_index = value[1:0];
            default:           frame_select = value[0];
         endcase
      endfunction

      function logic [15:0] read_half(int idx);
         int a;
         a = idx % VIDEO_WORDS;
         if (!vram_set[a] && !missing) begin
            missing = 1;
            missing_pal = 0;
            missing_addr = a;
         end
         touched.push_back(a);
         return vram[a];
      endfunction

      function logic [7:0] read_byte(int baddr);
         logic [15:0] h;
         h = read_half(baddr / 2);
         return baddr[0] ? h[15:8] : h[7:0];
      endfunction

      function logic [15:0] read_pal(int idx);
         int a;
         a = idx % PAL_ENTRIES;
         if (!palette_set[a] && !missing) begin
            missing = 1;
            missing_pal = 1;
            missing_addr = a;
         end
         return palette[a];
      endfunction

      // results below are {inside, colour}
      function logic [16:0] text_pixel(int x, int y);
         int w, h, blk, ent, tile, tx, ty, cbase, v;
         w = layer_control[14] ? 512 : 256;
         h = layer_control[15] ? 512 : 256;
         if (x >= w || y >= h) return '0;
         cbase = int'(layer_control[3:2]) * 'h4000;
         blk = (x >= 256 ? 1 : 0) + (y >= 256 ? (w > 256 ? 2 : 1) : 0);
         ent = read_half(int'(layer_control[12:8]) * 'h400 + blk * 'h400
                         + (y % 256) / 8 * 32 + (x % 256) / 8);
         tile = ent % 1024;
         tx = x % 8;
         ty = y % 8;
         if (ent[10]) tx = 7 - tx;
         if (ent[11]) ty = 7 - ty;
         if (layer_control[7])
            return {1'b1, read_pal(read_byte(cbase + tile * 64 + ty * 8 + tx))};
         v = read_byte(cbase + tile * 32 + ty * 4 + tx / 2);
         v = (tx % 2 != 0) ? v / 16 : v % 16;
         return {1'b1, read_pal((ent / 4096) * 16 + v)};
      endfunction

      function logic [16:0] rot_pixel(int x, int y);
         int n, cbase, sbase, tile;
         n = 128 << layer_control[15:14];
         if (x >= n || y >= n) return '0;
         cbase = int'(layer_control[3:2]) * 'h4000;
         sbase = int'(layer_control[12:8]) * 'h800;
         tile = read_byte(sbase + x / 8 + (y / 8) * (n / 8));
         return {1'b1, read_pal(read_byte(cbase + tile * 64 + (y % 8) * 8 + x % 8))};
      endfunction

      function logic [16:0] fetch_pixel(int x, int y);
         int page;
         page = frame_select ? int'(PAGE_BYTES) : 0;
         case (display_mode)
            MODE_TEXT:     return text_pixel(x, y);
            MODE_MIXED:    return (layer_index == ROT_LAYER) ? rot_pixel(x, y)
                                                             : text_pixel(x, y);
            MODE_ROTATION: return rot_pixel(x, y);
            MODE_BMP_WIDE: begin
               if (x >= BMP_WIDE_W || y >= BMP_WIDE_H) return '0;
               return {1'b1, read_half(y * 240 + x)};
            end
            MODE_BMP_IDX: begin
               if (x >= BMP_WIDE_W || y >= BMP_WIDE_H) return '0;
               return {1'b1, read_pal(read_byte(page + y * 240 + x))};
            end
            MODE_BMP_NARR: begin
               if (x >= BMP_NARR_W || y >= BMP_NARR_H) return '0;
               return {1'b1, read_half(page / 2 + y * 160 + x)};
            end
            default: return '0;
         endcase
      endfunction

      // tells whether the pixel still needs an entry that was never loaded
      function bit probe(int x, int y);
         missing = 0;
         touched.delete();
         void'(fetch_pixel(x, y));
         return missing;
      endfunction

      function void note_request(op_type op, logic [15:0] addr, logic [15:0] value,
                                 logic [9:0] x, logic [9:0] y);
         logic [16:0] r;
         pixel_type   p;
         case (op)
            OP_WRITE_VIDEO: begin
               vram[addr] = value;
               vram_set[addr] = 1;
            end
            OP_WRITE_PALETTE: begin
               palette[addr[7:0]] = value;
               palette_set[addr[7:0]] = 1;
            end
            OP_RENDER: begin
               void'(probe(x, y));
               r = fetch_pixel(x, y);
               p.red = {r[4:0], 3'b000};
               p.green = {r[9:5], 3'b000};
               p.blue = {r[14:10], 3'b000};
               p.outside_map = !r[16];
               pixels_due.push_back(p);
            end
            default: ;
         endcase
      endfunction

      function void check_pixel(logic [23:0] data, logic flag);
         pixel_type e;
         if (pixels_due.size() == 0) begin
            $error("unexpected pixel: rgb %h outside_map %0d", data, flag);
            errors++;
            return;
         end
         e = pixels_due.pop_front();
         if (data[7:0] !== e.red) begin
            $error("red: expected %0d, got %0d", e.red, data[7:0]);
            errors++;
         end
         if (data[15:8] !== e.green) begin
            $error("green: expected %0d, got %0d", e.green, data[15:8]);
            errors++;
         end
         if (data[23:16] !== e.blue) begin
            $error("blue: expected %0d, got %0d", e.blue, data[23:16]);
            errors++;
         end
         if (flag !== e.outside_map) begin
            $error("outside_map: expected %0d, got %0d", e.outside_map, flag);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [1:0]             csr_index  = '0;
   logic [15:0]            csr_wdata  = '0;

   bg_pixel_scoreboard_type sb = new;
   int         send_idle_pct = 0;
   int         rcv_idle_pct  = 0;
   int         items_sent    = 0;
   int         quiet_cycles  = 0;
   logic [9:0] last_x = '0;
   logic [9:0] last_y = '0;

   tiled_background_pixel_fetch_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic push_request(op_type op, logic [15:0] addr, logic [15:0] value,
                               logic [9:0] x, logic [9:0] y);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {4'b0000, y, x, value, addr};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, addr, value, x, y);
      if (op != OP_RESERVED) items_sent++;
      @(negedge clock);
   endtask

   // loads whatever the pixel still lacks, then renders it
   task automatic render_at(logic [9:0] x, logic [9:0] y);
      while (sb.probe(x, y)) begin
         if (sb.missing_pal) begin
            push_request(OP_WRITE_PALETTE, {8'($urandom), 8'(sb.missing_addr)},
                         16'($urandom), 10'($urandom), 10'($urandom));
         end else begin
            push_request(OP_WRITE_VIDEO, 16'(sb.missing_addr), 16'($urandom),
                         10'($urandom), 10'($urandom));
         end
      end
      last_x = x;
      last_y = y;
      push_request(OP_RENDER, 16'($urandom), 16'($urandom), x, y);
   endtask

   task automatic drain(int settle);
      req_tvalid <= 1'b0;
      while (sb.pixels_due.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      sb.set_reg(index, value);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(logic [15:0] lc, logic [2:0] mode, logic [1:0] layer,
                            logic frame);
      drain(SETTLE);
      write_csr(CSR_LAYER_CONTROL, lc);
      write_csr(CSR_DISPLAY_MODE, {13'd0, mode});
      write_csr(CSR_LAYER_INDEX, {14'd0, layer});
      write_csr(CSR_FRAME_SELECT, {15'd0, frame});
   endtask

   // {y, x} inside the map of the current setting
   function automatic logic [19:0] pick_in_map();
      int         w, h;
      logic [1:0] sz;
      sz = sb.layer_control[15:14];
      w = 1024;
      h = 1024;
      if (sb.display_mode == MODE_TEXT ||
          (sb.display_mode == MODE_MIXED && sb.layer_index != ROT_LAYER)) begin
         w = sz[0] ? 512 : 256;
         h = sz[1] ? 512 : 256;
      end else if (sb.display_mode == MODE_ROTATION || sb.display_mode == MODE_MIXED) begin
         w = 128 << sz;
         h = w;
      end else if (sb.display_mode == MODE_BMP_WIDE || sb.display_mode == MODE_BMP_IDX) begin
         w = BMP_WIDE_W;
         h = BMP_WIDE_H;
      end else if (sb.display_mode == MODE_BMP_NARR) begin
         w = BMP_NARR_W;
         h = BMP_NARR_H;
      end
      return {10'($urandom_range(0, h - 1)), 10'($urandom_range(0, w - 1))};
   endfunction

   task automatic random_item();
      int         pick;
      logic [19:0] yx;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         yx = pick_in_map();
         render_at(yx[9:0], yx[19:10]);
      end else if (pick < 75) begin
         render_at(10'($urandom), 10'($urandom));
      end else if (pick < 85 && sb.touched.size() != 0) begin
         // overwrite a word the last pixel used, then render it again
         push_request(OP_WRITE_VIDEO,
                      16'(sb.touched[$urandom_range(0, sb.touched.size() - 1)]),
                      16'($urandom), 10'($urandom), 10'($urandom));
         render_at(last_x, last_y);
      end else if (pick < 92) begin
         push_request(OP_WRITE_VIDEO, 16'($urandom), 16'($urandom),
                      10'($urandom), 10'($urandom));
      end else if (pick < 97) begin
         push_request(OP_WRITE_PALETTE, 16'($urandom), 16'($urandom),
                      10'($urandom), 10'($urandom));
      end else begin
         push_request(OP_RESERVED, 16'($urandom), 16'($urandom),
                      10'($urandom), 10'($urandom));
      end
   endtask

   initial begin
      int          base;
      logic [15:0] lc;
      logic [1:0]  layer;
      logic        frame;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 24;
      rcv_idle_pct = 60;
      configure(16'h0000, MODE_TEXT, 2'd0, 1'b0);
      push_request(OP_WRITE_PALETTE, 16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF);
      push_request(OP_WRITE_VIDEO, 16'hFFFF, 16'hFFFF, 10'h000, 10'h000);
      push_request(OP_RESERVED, 16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF);
      render_at(10'd0, 10'd0);
      render_at(10'd255, 10'd255);
      render_at(10'd256, 10'd0);
      render_at(10'h3FF, 10'h3FF);
      // layer 3 in mixed mode is a text layer
      configure(16'hFFFF, MODE_MIXED, 2'd3, 1'b1);
      render_at(10'd511, 10'd511);
      render_at(10'd300, 10'd100);
      render_at(10'd100, 10'd300);
      render_at(10'd512, 10'd0);
      configure(16'hFFFF, MODE_MIXED, ROT_LAYER, 1'b1);
      render_at(10'h3FF, 10'h3FF);
      render_at(10'd0, 10'd0);
      configure(16'h0000, MODE_ROTATION, 2'd0, 1'b0);
      render_at(10'd127, 10'd127);
      render_at(10'd128, 10'd0);
      configure(16'h0000, MODE_BMP_WIDE, 2'd0, 1'b0);
      render_at(10'd239, 10'd159);
      render_at(10'd240, 10'd0);
      configure(16'h0000, MODE_BMP_IDX, 2'd0, 1'b1);
      render_at(10'd239, 10'd159);
      configure(16'h0000, MODE_BMP_NARR, 2'd0, 1'b1);
      render_at(10'd159, 10'd127);
      render_at(10'd0, 10'd128);
      configure(16'h0000, MODE_SPARE_6, 2'd0, 1'b0);
      render_at(10'd5, 10'd5);
      configure(16'h0000, MODE_SPARE_7, 2'd0, 1'b0);
      render_at(10'd0, 10'd0);

      base = items_sent;
      for (int p = 0; p < 12; p++) begin
         if (p < 4) begin
            send_idle_pct = 24;
            rcv_idle_pct = 60;
         end else if (p < 8) begin
            send_idle_pct = 60;
            rcv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         lc = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom);
         layer = (p == 1) ? 2'd3 : (p == 7) ? ROT_LAYER : 2'($urandom);
         frame = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom);
         configure(lc, 3'(p % 6), layer, frame);
         while (items_sent - base < (p + 1) * RANDOM_ITEMS / 12) random_item();
      end

      drain(20);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
